@@ src/multi_channel_deadline_timer_assert.svh @@
// ----------------------------------------------------------------------------
// multi_channel_deadline_timer assertion macros
// concurrent assertion helpers, compiled out for synthesis
// ----------------------------------------------------------------------------
`ifndef MULTI_CHANNEL_DEADLINE_TIMER_ASSERT_SVH
`define MULTI_CHANNEL_DEADLINE_TIMER_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define MCDT_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication
`define MCDT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`else

`define MCDT_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define MCDT_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

@@ src/mcdt_pkg.sv @@
// ----------------------------------------------------------------------------
// mcdt_pkg
// shared types and constants of the multi-channel deadline timer
// ----------------------------------------------------------------------------
package mcdt_pkg;

   localparam int TICKS_W    = 56;
   localparam int WRAP_W     = 32;
   localparam int PRESCALE_W = 12;
   localparam int MASK_W     = 4;
   localparam int CHAN_W     = 2;
   localparam int KIND_W     = 2;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [KIND_W-1:0] KIND_TICK  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_START = 2'd1;
   localparam logic [KIND_W-1:0] KIND_STOP  = 2'd2;

   // register index, taken from paddr[2]
   localparam logic CSR_PRESCALE = 1'b0;

   localparam logic [TICKS_W-1:0] MIN_TICKS = 56'd2;

   typedef struct packed {
      logic [KIND_W-1:0]  kind;
      logic [CHAN_W-1:0]  channel;
      logic               repeat_req;
      logic [TICKS_W-1:0] interval;
   } req_item_type;

   typedef struct packed {
      logic [MASK_W-1:0] fired_mask;
      logic [MASK_W-1:0] active_mask;
      logic              rejected;
   } rsp_item_type;

   typedef struct packed {
      logic enable;
      logic advance;
      logic wrap;
      logic start;
      logic stop;
      logic fire_now;
      logic periodic;
   } chan_ctl_type;

   typedef struct packed {
      logic fired;
      logic active;
      logic active_next;
   } chan_sts_type;

endpackage

@@ src/multi_channel_deadline_timer.sv @@
// ----------------------------------------------------------------------------
// multi_channel_deadline_timer
// timer channels on one prescaled counter that runs while any channel is active, one result per beat
// ----------------------------------------------------------------------------
// usage:
//   req channel: one beat per tick, start or stop command. kind selects the
//   command; channel applies to start and stop, repeat_req and interval to start.
//   rsp channel: exactly one beat per request beat, in order, carrying the
//   channels that fired, the channels still running and a reject flag.
//   psel/penable/pwrite/paddr/pwdata: prescale divider at address 0, to be
//   written only while no request is in flight; the block does not enforce it.
// timing:
//   a request beat is captured in the input register, then the whole counter
//   advance, compare and rearm for all channels is done combinationally into
//   the result register, which drives rsp_valid. one beat is taken every cycle
//   unless rsp_stall holds a full result register; the rearm adder per channel
//   sets the critical path.
// reset: counter, prescaler, divider and channel flags cleared, no beat held.
// stall: while rsp_stall holds a full result register, a waiting request
//   beat stays in the input register and req_stall rises; nothing is lost.
// ----------------------------------------------------------------------------
`include "multi_channel_deadline_timer_assert.svh"

module multi_channel_deadline_timer #(
   parameter int CHANNELS     = 4,
   parameter int COUNTER_BITS = 24
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  mcdt_pkg::req_item_type          req_item,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output mcdt_pkg::rsp_item_type          rsp_item,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [mcdt_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [mcdt_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [mcdt_pkg::CSR_DATA_W-1:0] prdata,
   output logic                            pready
);
   import mcdt_pkg::*;

   localparam int ADDRESSABLE = 2 ** CHAN_W;

   logic [PRESCALE_W-1:0]   div_ff;
   logic [PRESCALE_W-1:0]   pre_ff, pre_in;
   logic [COUNTER_BITS-1:0] counter_ff, counter_in;
   logic                    running_ff, running_in;

   logic                    in_valid_ff;
   req_item_type            in_item_ff;
   logic                    out_valid_ff;
   rsp_item_type            out_item_ff, out_item_in;

   logic                    go;
   logic                    is_tick, is_start, is_stop;
   logic                    advance;
   logic [COUNTER_BITS-1:0] count_next;
   logic [COUNTER_BITS-1:0] arm_base;
   logic                    ticks_zero;
   logic [TICKS_W-1:0]      start_ticks;
   logic                    start_arm_any;
   logic                    reject;

   logic [CHANNELS-1:0]     chan_hit;
   logic [CHANNELS-1:0]     fired_vec;
   logic [CHANNELS-1:0]     active_vec;
   logic [CHANNELS-1:0]     active_next_vec;
   chan_ctl_type            ctl [CHANNELS];
   chan_sts_type            sts [CHANNELS];

   // ---------------- configuration port ----------------
   assign pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         div_ff <= '0;
      end else if (psel && penable && pwrite && (paddr[2] == CSR_PRESCALE)) begin
         div_ff <= pwdata[PRESCALE_W-1:0];
      end
   end

   assign prdata = (paddr[2] == CSR_PRESCALE) ? CSR_DATA_W'(div_ff) : '0;

   // ---------------- handshake ----------------
   assign go        = in_valid_ff && !(out_valid_ff && rsp_stall);
   assign req_stall = in_valid_ff && out_valid_ff && rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (!req_stall) begin
            in_valid_ff <= req_valid;
         end
         if (go) begin
            out_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_item_ff <= req_item;
      end
      if (go) begin
         out_item_ff <= out_item_in;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_item  = out_item_ff;

   // ---------------- decode ----------------
   assign is_tick  = (in_item_ff.kind == KIND_TICK);
   assign is_start = (in_item_ff.kind == KIND_START);
   assign is_stop  = (in_item_ff.kind == KIND_STOP);

   assign ticks_zero  = (in_item_ff.interval == '0);
   assign start_ticks = (in_item_ff.interval < MIN_TICKS) ? MIN_TICKS : in_item_ff.interval;

   assign advance    = is_tick && running_ff && (pre_ff >= div_ff);
   assign count_next = counter_ff + 1'b1;
   // start arms from the current count, periodic rearm from the advanced one
   assign arm_base   = is_tick ? count_next : counter_ff;

   assign start_arm_any = is_start && (|chan_hit) && !ticks_zero;
   assign reject        = is_start && (|chan_hit) && ticks_zero && in_item_ff.repeat_req;

   // ---------------- channels ----------------
   for (genvar i = 0; i < CHANNELS; i++) begin : g_chan
      assign chan_hit[i] = (i < ADDRESSABLE) && (in_item_ff.channel == CHAN_W'(i));

      assign ctl[i].enable   = go;
      assign ctl[i].advance  = advance;
      assign ctl[i].wrap     = (count_next == '0);
      assign ctl[i].start    = chan_hit[i] && is_start && !ticks_zero;
      assign ctl[i].stop     = chan_hit[i] && (is_stop ||
                               (is_start && ticks_zero && !in_item_ff.repeat_req));
      assign ctl[i].fire_now = chan_hit[i] && is_start && ticks_zero &&
                               !in_item_ff.repeat_req;
      assign ctl[i].periodic = in_item_ff.repeat_req;

      mcdt_channel #(
         .COUNTER_BITS (COUNTER_BITS)
      ) u_chan (
         .clock       (clock),
         .reset       (reset),
         .ctl         (ctl[i]),
         .count_next  (count_next),
         .arm_base    (arm_base),
         .start_ticks (start_ticks),
         .sts         (sts[i])
      );

      assign fired_vec[i]       = sts[i].fired;
      assign active_vec[i]      = sts[i].active;
      assign active_next_vec[i] = sts[i].active_next;
   end

   // ---------------- counter and prescaler ----------------
   always_comb begin
      pre_in     = pre_ff;
      counter_in = counter_ff;
      running_in = running_ff;
      if (go) begin
         running_in = |active_next_vec;
         if (is_tick && running_ff) begin
            if (advance) begin
               pre_in     = '0;
               counter_in = count_next;
            end else begin
               pre_in = pre_ff + 1'b1;
            end
         end else if (start_arm_any && !running_ff) begin
            pre_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pre_ff     <= '0;
         counter_ff <= '0;
         running_ff <= 1'b0;
      end else begin
         pre_ff     <= pre_in;
         counter_ff <= counter_in;
         running_ff <= running_in;
      end
   end

   // ---------------- result ----------------
   for (genvar m = 0; m < MASK_W; m++) begin : g_mask
      if (m < CHANNELS) begin : g_live
         assign out_item_in.fired_mask[m]  = fired_vec[m];
         assign out_item_in.active_mask[m] = active_next_vec[m];
      end else begin : g_none
         assign out_item_in.fired_mask[m]  = 1'b0;
         assign out_item_in.active_mask[m] = 1'b0;
      end
   end
   assign out_item_in.rejected = reject;

   `MCDT_ASSERT_IMPLY(a_running_tracks_active, clock, reset, 1'b1,
      running_ff == (|active_vec))
   `MCDT_ASSERT_NEXT(a_counter_holds_idle, clock, reset, !running_ff,
      counter_ff == $past(counter_ff))
   `MCDT_ASSERT_IMPLY(a_reject_fires_none, clock, reset, rsp_valid && rsp_item.rejected,
      rsp_item.fired_mask == '0)
   `MCDT_ASSERT_IMPLY(a_stall_only_full, clock, reset, req_stall,
      out_valid_ff && in_valid_ff)

endmodule

@@ src/mcdt_channel.sv @@
// ----------------------------------------------------------------------------
// mcdt_channel
// state and update logic of one timer channel: compare, wrap count, rearm
// ----------------------------------------------------------------------------
`include "multi_channel_deadline_timer_assert.svh"

module mcdt_channel #(
   parameter int COUNTER_BITS = 24
) (
   input  logic                        clock,
   input  logic                        reset,
   input  mcdt_pkg::chan_ctl_type      ctl,
   input  logic [COUNTER_BITS-1:0]     count_next,
   input  logic [COUNTER_BITS-1:0]     arm_base,
   input  logic [mcdt_pkg::TICKS_W-1:0] start_ticks,
   output mcdt_pkg::chan_sts_type      sts
);
   import mcdt_pkg::*;

   localparam int SUM_W = TICKS_W + 1;

   logic [COUNTER_BITS-1:0] cmp_ff, cmp_in;
   logic [WRAP_W-1:0]       ovf_ff, ovf_in;
   logic                    armed_ff, armed_in;
   logic                    active_ff, active_in;
   logic                    periodic_ff, periodic_in;
   logic [TICKS_W-1:0]      period_ff, period_in;

   logic                    dec;
   logic [WRAP_W-1:0]       ovf_mid;
   logic                    armed_mid;
   logic                    hit;
   logic [TICKS_W-1:0]      arm_ticks;
   logic [SUM_W-1:0]        sum;
   logic [SUM_W-1:0]        wraps_full;
   logic [WRAP_W-1:0]       wraps;

   // wrap first counts down, then the compare may match in the same advance
   assign dec       = ctl.advance && ctl.wrap && active_ff && (ovf_ff != '0);
   assign ovf_mid   = dec ? ovf_ff - 1'b1 : ovf_ff;
   assign armed_mid = armed_ff || (dec && (ovf_mid == '0));
   assign hit       = ctl.advance && active_ff && armed_mid && (count_next == cmp_ff);

   assign arm_ticks  = ctl.start ? start_ticks : period_ff;
   assign sum        = SUM_W'(arm_base) + SUM_W'(arm_ticks);
   assign wraps_full = sum >> COUNTER_BITS;
   assign wraps      = (|wraps_full[SUM_W-1:WRAP_W]) ? '1 : wraps_full[WRAP_W-1:0];

   always_comb begin
      cmp_in      = cmp_ff;
      ovf_in      = ovf_ff;
      armed_in    = armed_ff;
      active_in   = active_ff;
      periodic_in = periodic_ff;
      period_in   = period_ff;
      if (ctl.enable) begin
         priority if (ctl.stop) begin
            active_in   = 1'b0;
            periodic_in = 1'b0;
            armed_in    = 1'b0;
            ovf_in      = '0;
         end else if (ctl.start) begin
            periodic_in = ctl.periodic;
            period_in   = start_ticks;
            active_in   = 1'b1;
            cmp_in      = sum[COUNTER_BITS-1:0];
            ovf_in      = wraps;
            armed_in    = (wraps == '0);
         end else if (hit && periodic_ff) begin
            cmp_in   = sum[COUNTER_BITS-1:0];
            ovf_in   = wraps;
            armed_in = (wraps == '0);
         end else if (hit) begin
            active_in   = 1'b0;
            periodic_in = 1'b0;
            armed_in    = 1'b0;
            ovf_in      = '0;
         end else begin
            ovf_in   = ovf_mid;
            armed_in = armed_mid;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ovf_ff      <= '0;
         armed_ff    <= 1'b0;
         active_ff   <= 1'b0;
         periodic_ff <= 1'b0;
      end else begin
         ovf_ff      <= ovf_in;
         armed_ff    <= armed_in;
         active_ff   <= active_in;
         periodic_ff <= periodic_in;
      end
   end

   always_ff @(posedge clock) begin
      cmp_ff    <= cmp_in;
      period_ff <= period_in;
   end

   assign sts.fired       = ctl.enable && (hit || ctl.fire_now);
   assign sts.active      = active_ff;
   assign sts.active_next = active_in;

   `MCDT_ASSERT_IMPLY(a_armed_needs_active, clock, reset, armed_ff, active_ff)
   `MCDT_ASSERT_IMPLY(a_periodic_needs_active, clock, reset, periodic_ff, active_ff)
   `MCDT_ASSERT_NEXT(a_stop_clears, clock, reset, ctl.enable && ctl.stop,
      !active_ff && !armed_ff && (ovf_ff == '0))

endmodule

@@ sim/mcdt_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcdt_checker
// watches the request, result and register ports of the deadline timer,
// keeps its own copy of the counter and the four channels, and compares
// every result beat field by field against the oldest due result
// ----------------------------------------------------------------------------
module mcdt_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  logic                            req_stall,
   input  mcdt_pkg::req_item_type          req_item,
   input  logic                            rsp_valid,
   input  logic                            rsp_stall,
   input  mcdt_pkg::rsp_item_type          rsp_item,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [mcdt_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [mcdt_pkg::CSR_DATA_W-1:0] pwdata,
   input  logic [mcdt_pkg::CSR_DATA_W-1:0] prdata,
   input  logic                            pready,
   output int                              fail_count,
   output int                              pending_count,
   output int                              checked_count,
   output int                              expiry_count,
   output int                              refusal_count
);
   import mcdt_pkg::*;

   localparam int NCH        = 4;
   localparam int CNT_W      = 24;
   localparam int REPORT_MAX = 30;

   logic [CNT_W-1:0]      tmr_counter;
   logic [PRESCALE_W-1:0] presc_cnt;
   logic [PRESCALE_W-1:0] divider;
   logic                  running;
   logic [CNT_W-1:0]      cmp_val    [NCH];
   logic [WRAP_W-1:0]     wraps_left [NCH];
   logic                  armed      [NCH];
   logic                  active     [NCH];
   logic                  periodic   [NCH];
   logic [TICKS_W-1:0]    period     [NCH];

   rsp_item_type due_results [$];
   int mismatches;
   int checked;
   int expiries;
   int refusals;

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      if (mismatches < REPORT_MAX)
         $display("%0t mismatch: %s got %0h want %0h", $realtime, what, got, want);
      mismatches++;
   endtask

   // split a target into a compare value and a number of counter wraps
   task automatic arm_channel(input int ch, input logic [TICKS_W-1:0] ticks);
      logic [TICKS_W:0]      sum;
      logic [TICKS_W-CNT_W:0] wraps;
      sum   = {{(TICKS_W-CNT_W+1){1'b0}}, tmr_counter} + {1'b0, ticks};
      wraps = sum[TICKS_W:CNT_W];
      cmp_val[ch]    = sum[CNT_W-1:0];
      wraps_left[ch] = (wraps > {1'b0, {WRAP_W{1'b1}}}) ? {WRAP_W{1'b1}} : wraps[WRAP_W-1:0];
      armed[ch]      = (wraps == '0);
   endtask

   task automatic halt_channel(input int ch);
      active[ch]     = 1'b0;
      periodic[ch]   = 1'b0;
      armed[ch]      = 1'b0;
      wraps_left[ch] = '0;
   endtask

   task automatic advance_counter(output logic [MASK_W-1:0] fired);
      fired = '0;
      tmr_counter = tmr_counter + 1'b1;
      if (tmr_counter == '0) begin
         for (int i = 0; i < NCH; i++) begin
            if (active[i] && wraps_left[i] != '0) begin
               wraps_left[i] = wraps_left[i] - 1'b1;
               if (wraps_left[i] == '0)
                  armed[i] = 1'b1;
            end
         end
      end
      for (int i = 0; i < NCH; i++) begin
         if (active[i] && armed[i] && tmr_counter == cmp_val[i]) begin
            fired[i] = 1'b1;
            if (periodic[i])
               arm_channel(i, period[i]);
            else
               halt_channel(i);
         end
      end
   endtask

   task automatic timer_step(input req_item_type it, output rsp_item_type r);
      logic [MASK_W-1:0]  fired;
      logic [TICKS_W-1:0] ticks;
      int                 ch;
      fired = '0;
      r     = '0;
      ch    = int'(it.channel);
      case (it.kind)
         KIND_TICK: begin
            if (running) begin
               if (presc_cnt >= divider) begin
                  presc_cnt = '0;
                  advance_counter(fired);
               end else begin
                  presc_cnt = presc_cnt + 1'b1;
               end
            end
         end
         KIND_START: begin
            if (it.interval == '0) begin
               if (it.repeat_req) begin
                  r.rejected = 1'b1;
               end else begin
                  halt_channel(ch);
                  fired[ch] = 1'b1;
               end
            end else begin
               ticks = (it.interval < MIN_TICKS) ? MIN_TICKS : it.interval;
               // prescaler restarts when the counter starts from idle
               if (!running)
                  presc_cnt = '0;
               periodic[ch] = it.repeat_req;
               period[ch]   = ticks;
               arm_channel(ch, ticks);
               active[ch] = 1'b1;
            end
         end
         KIND_STOP: halt_channel(ch);
         default: ;
      endcase
      running = 1'b0;
      for (int i = 0; i < NCH; i++) begin
         running = running | active[i];
         r.active_mask[i] = active[i];
      end
      r.fired_mask = fired;
   endtask

   always @(posedge clock) begin
      rsp_item_type want;
      if (reset) begin
         tmr_counter = '0;
         presc_cnt   = '0;
         divider     = '0;
         running     = 1'b0;
         for (int i = 0; i < NCH; i++) begin
            cmp_val[i]    = '0;
            wraps_left[i] = '0;
            armed[i]      = 1'b0;
            active[i]     = 1'b0;
            periodic[i]   = 1'b0;
            period[i]     = '0;
         end
         due_results.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (due_results.size() == 0) begin
               report_mismatch("result beat with no request waiting", rsp_item, '0);
            end else begin
               want = due_results.pop_front();
               if (rsp_item.fired_mask !== want.fired_mask)
                  report_mismatch("fired_mask", rsp_item.fired_mask, want.fired_mask);
               if (rsp_item.active_mask !== want.active_mask)
                  report_mismatch("active_mask", rsp_item.active_mask, want.active_mask);
               if (rsp_item.rejected !== want.rejected)
                  report_mismatch("rejected", rsp_item.rejected, want.rejected);
               checked++;
               if (want.fired_mask != '0)
                  expiries++;
               if (want.rejected)
                  refusals++;
            end
         end
         if (req_valid && !req_stall) begin
            timer_step(req_item, want);
            due_results.push_back(want);
         end
         if (psel && penable && pready && paddr[2] == CSR_PRESCALE) begin
            if (pwrite)
               divider = pwdata[PRESCALE_W-1:0];
            else if (prdata[PRESCALE_W-1:0] !== divider)
               report_mismatch("prescale readback", prdata, divider);
         end
      end
      fail_count    <= mismatches;
      pending_count <= due_results.size();
      checked_count <= checked;
      expiry_count  <= expiries;
      refusal_count <= refusals;
   end

endmodule

@@ sim/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// stimulus for the multi-channel deadline timer: a directed opening, then
// random phases under several prescale settings and idling patterns
// ----------------------------------------------------------------------------
module tb;
   import mcdt_pkg::*;

   localparam logic [KIND_W-1:0]     KIND_UNUSED   = 2'd3;
   localparam logic [CSR_ADDR_W-1:0] PRESCALE_ADDR = {CSR_PRESCALE, 2'b00};
   localparam logic [TICKS_W-1:0]    TICKS_MAX     = {TICKS_W{1'b1}};
   localparam int NUM_PHASES  = 6;
   localparam int PHASE_ITEMS = 300;
   localparam int QUIET_LIMIT = 2000;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   req_item_type          req_item;
   logic                  rsp_valid;
   logic                  rsp_stall;
   rsp_item_type          rsp_item;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;
   int                    fail_count;
   int                    pending_count;
   int                    checked_count;
   int                    expiry_count;
   int                    refusal_count;

   int idle_pct  = 0;
   int stall_pct = 0;
   int sent      = 0;
   int quiet     = 0;

   multi_channel_deadline_timer dut (.*);

   mcdt_checker chk (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock)
      rsp_stall <= ($urandom_range(0, 99) < stall_pct);

   // ends the run when no beat has moved for too long
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (psel && penable))
         quiet <= 0;
      else
         quiet <= quiet + 1;
      if (quiet >= QUIET_LIMIT) begin
         $display("watchdog: nothing moved for %0d cycles", QUIET_LIMIT);
         $display("FAILED: results differ");
         $finish;
      end
   end

   function automatic req_item_type make_req(input logic [KIND_W-1:0] kind, input int ch,
                                             input logic rep, input logic [TICKS_W-1:0] ticks);
      req_item_type it;
      it.kind       = kind;
      it.channel    = ch[CHAN_W-1:0];
      it.repeat_req = rep;
      it.interval   = ticks;
      return it;
   endfunction

   // mostly ticks and short starts so channels keep firing, plus noise
   function automatic req_item_type random_request();
      req_item_type it;
      logic [63:0]  wide;
      int           roll;
      wide          = {$urandom, $urandom};
      it.kind       = KIND_TICK;
      it.channel    = CHAN_W'($urandom_range(0, 3));
      it.repeat_req = 1'($urandom_range(0, 1));
      it.interval   = wide[TICKS_W-1:0];
      roll          = $urandom_range(0, 99);
      if (roll < 62) begin
         it.kind = KIND_TICK;
      end else if (roll < 80) begin
         it.kind     = KIND_START;
         it.interval = TICKS_W'($urandom_range(1, 24));
      end else if (roll < 84) begin
         it.kind     = KIND_START;
         it.interval = '0;
      end else if (roll < 88) begin
         it.kind = KIND_START;
      end else if (roll < 97) begin
         it.kind = KIND_STOP;
      end else begin
         it.kind = KIND_UNUSED;
      end
      return it;
   endfunction

   task automatic send_request(input req_item_type it);
      while ($urandom_range(0, 99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_item  <= it;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      sent++;
   endtask

   task automatic csr_access(input logic wr, input logic [CSR_DATA_W-1:0] data);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= wr;
      paddr   <= PRESCALE_ADDR;
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready)
         @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic program_divider(input logic [PRESCALE_W-1:0] div);
      logic [CSR_DATA_W-1:0] data;
      // upper bits are junk, only the low bits hold the divider
      data = $urandom;
      data[PRESCALE_W-1:0] = div;
      csr_access(1'b1, data);
      csr_access(1'b0, '0);
   endtask

   // wait until every result beat is back, then let the pipeline settle
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   initial begin
      logic [PRESCALE_W-1:0] div;
      reset     = 1'b1;
      req_valid = 1'b0;
      req_item  = '0;
      rsp_stall = 1'b0;
      psel      = 1'b0;
      penable   = 1'b0;
      pwrite    = 1'b0;
      paddr     = '0;
      pwdata    = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      program_divider('0);

      // directed opening with no idling
      send_request(make_req(KIND_TICK, 0, 1'b0, '0));
      send_request(make_req(KIND_UNUSED, 3, 1'b1, TICKS_MAX));
      send_request(make_req(KIND_START, 0, 1'b0, '0));
      send_request(make_req(KIND_START, 1, 1'b1, '0));
      send_request(make_req(KIND_START, 0, 1'b0, 56'd1));
      repeat (3) send_request(make_req(KIND_TICK, 0, 1'b0, '0));
      send_request(make_req(KIND_START, 1, 1'b1, 56'd3));
      send_request(make_req(KIND_START, 2, 1'b0, 56'd5));
      // huge count with a nonzero counter saturates the wrap count
      send_request(make_req(KIND_START, 3, 1'b1, TICKS_MAX));
      repeat (6) send_request(make_req(KIND_TICK, 3, 1'b1, TICKS_MAX));
      send_request(make_req(KIND_STOP, 1, 1'b0, '0));
      send_request(make_req(KIND_STOP, 3, 1'b0, '0));
      send_request(make_req(KIND_STOP, 2, 1'b1, TICKS_MAX));
      send_request(make_req(KIND_START, 2, 1'b1, TICKS_MAX));
      send_request(make_req(KIND_STOP, 2, 1'b0, '0));
      send_request(make_req(KIND_START, 0, 1'b1, 56'd2));
      repeat (3) send_request(make_req(KIND_TICK, 0, 1'b0, '0));
      send_request(make_req(KIND_STOP, 0, 1'b0, '0));
      drain();

      for (int p = 0; p < NUM_PHASES; p++) begin
         case (p)
            0:       div = '0;
            1:       div = 12'd1;
            2:       div = {PRESCALE_W{1'b1}};
            3:       div = 12'd2;
            4:       div = PRESCALE_W'($urandom_range(0, 7));
            default: div = PRESCALE_W'($urandom_range(0, 4095));
         endcase
         program_divider(div);
         case (p % 4)
            0:       begin idle_pct = 0;  stall_pct = 0;  end
            1:       begin idle_pct = 47; stall_pct = 0;  end
            2:       begin idle_pct = 0;  stall_pct = 47; end
            default: begin idle_pct = 6;  stall_pct = 6;  end
         endcase
         repeat (PHASE_ITEMS) send_request(random_request());
         drain();
         stall_pct = 0;
      end

      $display("run covered %0d request beats over %0d prescale settings and four idling patterns",
               sent, NUM_PHASES + 1);
      $display("%0d results checked, %0d with expiries, %0d refused periodic starts",
               checked_count, expiry_count, refusal_count);
      if (fail_count == 0 && pending_count == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule
